### rtl/pvu_pkg.sv
package pvu_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 24;
  localparam int ANGLE_WIDTH   = 16;

  localparam int FRAC_BITS  = COORD_WIDTH / 2;
  localparam int GUARD_BITS = 4;
  // working width of the CORDIC datapath: guard bits plus room for gain growth
  localparam int IW = COORD_WIDTH + GUARD_BITS + 3;
  // rotation residual angle, signed, room for the summed arctangents
  localparam int ZW = 34;
  // width that saturation takes in
  localparam int SW = IW + 2;
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] ANGLE_HALF = 32'((64'd1 << (32 - ANGLE_WIDTH)) >> 1);

  localparam int IN_RAW     = 5 * COORD_WIDTH + 2 * ANGLE_WIDTH;
  localparam int IN_DATA_W  = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW    = 3 * COORD_WIDTH + ANGLE_WIDTH;
  localparam int OUT_DATA_W = ((OUT_RAW + 7) / 8) * 8;

  // pipeline depths of the sub-blocks
  localparam int ROT_LAT   = CORDIC_STAGES + 2;
  localparam int VEC_LAT   = CORDIC_STAGES + 3;
  localparam int TOTAL_LAT = 2 + ROT_LAT + 1 + VEC_LAT + 1;

  typedef enum logic [2:0] {
    FN_FROM_POINT = 3'd0,
    FN_TO_POINT   = 3'd1,
    FN_ADD        = 3'd2,
    FN_SUBTRACT   = 3'd3,
    FN_SCALE      = 3'd4,
    FN_ROTATE     = 3'd5,
    FN_NORMALIZE  = 3'd6
  } func_e;

  // operation, polar answer and a point that travel beside the CORDIC lanes
  typedef struct packed {
    logic [2:0]                    func;
    logic signed [COORD_WIDTH-1:0] mag;
    logic [31:0]                   ang;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
  } side_t;

  typedef struct packed {
    logic signed [IW-1:0] x;
    logic signed [ZW-1:0] z;
  } lane_t;

  function automatic logic [31:0] atan_lut(input int unsigned i);
    logic [31:0] r;
    unique case (i[4:0])
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    lo = -hi - SW'(1);
    if (v > hi) return COORD_WIDTH'(hi);
    if (v < lo) return COORD_WIDTH'(lo);
    return COORD_WIDTH'(v);
  endfunction

  function automatic logic [31:0] angle_in(input logic [ANGLE_WIDTH-1:0] a);
    return 32'(a) << (32 - ANGLE_WIDTH);
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] angle_out(input logic [31:0] z);
    logic [31:0] s;
    s = z + ANGLE_HALF;
    return ANGLE_WIDTH'(s >> (32 - ANGLE_WIDTH));
  endfunction

endpackage

### rtl/polar_vector_unit.sv
// Polar vector unit: CORDIC-based arithmetic on 2D vectors in polar form.
// Input stream: s_axis_tuser carries the operation code, s_axis_tdata the
// operands. Output stream: m_axis_tdata carries the polar and Cartesian
// answer, m_axis_tuser the flag for a magnitude above the threshold.
// The threshold is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, which the block leaves to the user.
// Throughput: one request per cycle while m_axis_tready is high. The rotation
// CORDIC lanes and the vectoring CORDIC each feed a gain multiply.
// The whole pipeline moves as one: s_axis_tready is high whenever the
// output register is empty or being taken. When the receiver holds
// m_axis_tready low with a result waiting, every stage holds and input is
// refused; nothing is dropped or repeated.
// Reset clears all valid bits and the threshold; the pipeline starts empty
// and can take a request as soon as reset ends.
module polar_vector_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // a_mag, a_angle, b_mag, b_angle, factor, x_in, y_in
  input  logic [pvu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func
  input  logic [2:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_mag, out_angle, out_x, out_y
  output logic [pvu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // magnitude above the threshold
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [22:0]                      cfg_wdata_i
);
  import pvu_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;

  localparam int O_AMAG = 0;
  localparam int O_AANG = O_AMAG + CW;
  localparam int O_BMAG = O_AANG + AW;
  localparam int O_BANG = O_BMAG + CW;
  localparam int O_FAC  = O_BANG + AW;
  localparam int O_XIN  = O_FAC + CW;
  localparam int O_YIN  = O_XIN + CW;

  logic en;
  logic vld_q [TOTAL_LAT];
  logic [22:0] thr_q;

  assign en            = !vld_q[TOTAL_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[TOTAL_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOTAL_LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < TOTAL_LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  lane_t lane_a, lane_b;
  side_t side_p;

  pvu_prep u_prep (
    .clk_i     (clk_i),
    .en_i      (en),
    .func_i    (s_axis_tuser),
    .a_mag_i   (s_axis_tdata[O_AMAG +: CW]),
    .a_angle_i (s_axis_tdata[O_AANG +: AW]),
    .b_mag_i   (s_axis_tdata[O_BMAG +: CW]),
    .b_angle_i (s_axis_tdata[O_BANG +: AW]),
    .factor_i  (s_axis_tdata[O_FAC +: CW]),
    .x_in_i    (s_axis_tdata[O_XIN +: CW]),
    .y_in_i    (s_axis_tdata[O_YIN +: CW]),
    .lane_a_o  (lane_a),
    .lane_b_o  (lane_b),
    .side_o    (side_p)
  );

  logic signed [CW-1:0] ax, ay, bx, by;

  pvu_rot u_rot_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .lane_i (lane_a),
    .x_o    (ax),
    .y_o    (ay)
  );

  pvu_rot u_rot_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .lane_i (lane_b),
    .x_o    (bx),
    .y_o    (by)
  );

  side_t side1_q [ROT_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q[0] <= side_p;
      for (int k = 1; k < ROT_LAT; k++) side1_q[k] <= side1_q[k-1];
    end
  end

  // combine: Cartesian answer and the point to vector back to polar
  side_t                side_c, side_c_q;
  logic signed [CW-1:0] sx, sy;

  always_comb begin
    side_c = side1_q[ROT_LAT-1];
    sx = sat_coord(SW'(ax) + SW'(bx));
    sy = sat_coord(SW'(ay) + SW'(by));
    if (side_c.func == FN_SUBTRACT) begin
      sx = sat_coord(SW'(ax) - SW'(bx));
      sy = sat_coord(SW'(ay) - SW'(by));
    end
    if (side_c.func == FN_ADD || side_c.func == FN_SUBTRACT) begin
      side_c.px = sx;
      side_c.py = sy;
    end else if (side_c.func != FN_FROM_POINT) begin
      side_c.px = ax;
      side_c.py = ay;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) side_c_q <= side_c;
  end

  logic signed [CW-1:0] vmag;
  logic [31:0]          vang;

  pvu_vec u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (side_c_q.px),
    .y_i   (side_c_q.py),
    .mag_o (vmag),
    .ang_o (vang)
  );

  side_t side2_q [VEC_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q[0] <= side_c_q;
      for (int k = 1; k < VEC_LAT; k++) side2_q[k] <= side2_q[k-1];
    end
  end

  // output register
  side_t                side_o;
  logic signed [CW-1:0] mag_d, mag_q, x_q, y_q;
  logic [31:0]          ang_d;
  logic [AW-1:0]        ang_q;
  logic [CW-1:0]        abs_mag;
  logic                 nz_q;

  assign side_o = side2_q[VEC_LAT-1];

  always_comb begin
    mag_d = side_o.mag;
    ang_d = side_o.ang;
    if (side_o.func == FN_FROM_POINT || side_o.func == FN_ADD ||
        side_o.func == FN_SUBTRACT) begin
      mag_d = vmag;
      ang_d = vang;
    end
  end

  assign abs_mag = mag_d[CW-1] ? unsigned'(-mag_d) : unsigned'(mag_d);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= mag_d;
      ang_q <= angle_out(ang_d);
      x_q   <= side_o.px;
      y_q   <= side_o.py;
      nz_q  <= abs_mag > CW'(thr_q);
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({y_q, x_q, ang_q, mag_q});
  assign m_axis_tuser = nz_q;

endmodule

### rtl/pvu_gain.sv
module pvu_gain (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [pvu_pkg::IW-1:0]           v_i,
  output logic signed [pvu_pkg::COORD_WIDTH-1:0]  y_o
);
  import pvu_pkg::*;

  localparam int PW = IW + GAIN_W;

  logic [IW-1:0]           abs_v;
  logic [PW-1:0]           prod_d, prod_q;
  logic                    neg_q;
  logic [PW:0]             rsum;
  logic [IW:0]             r;
  logic signed [SW-1:0]    g;
  logic signed [SW-1:0]    t;
  logic signed [COORD_WIDTH-1:0] y_d, y_q;

  assign abs_v  = v_i[IW-1] ? unsigned'(-v_i) : unsigned'(v_i);
  assign prod_d = PW'(abs_v) * PW'(GAIN_Q30);

  // round half away from zero on the magnitude, then round off the guard bits
  assign rsum = {1'b0, prod_q} + (PW + 1)'(1 << (GAIN_W - 1));
  assign r    = rsum[PW:GAIN_W];
  assign g    = neg_q ? -signed'(SW'(r)) : signed'(SW'(r));
  assign t    = (g + SW'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign y_d  = sat_coord(t);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= v_i[IW-1];
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

### rtl/pvu_prep.sv
module pvu_prep (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [2:0]                             func_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] a_mag_i,
  input  logic signed [pvu_pkg::ANGLE_WIDTH-1:0] a_angle_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] b_mag_i,
  input  logic signed [pvu_pkg::ANGLE_WIDTH-1:0] b_angle_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] factor_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] x_in_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] y_in_i,
  output pvu_pkg::lane_t                         lane_a_o,
  output pvu_pkg::lane_t                         lane_b_o,
  output pvu_pkg::side_t                         side_o
);
  import pvu_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW;

  // stage 1: operands and the scale product
  logic [2:0]           func_q;
  logic signed [CW-1:0] am_q, bm_q, xi_q, yi_q;
  logic [31:0]          aa_q, ba_q;
  logic [PW-1:0]        prod_q;
  logic                 neg_q;
  logic [CW-1:0]        ua, uf;

  assign ua = a_mag_i[CW-1] ? unsigned'(-a_mag_i) : unsigned'(a_mag_i);
  assign uf = factor_i[CW-1] ? unsigned'(-factor_i) : unsigned'(factor_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_q <= func_i;
      am_q   <= a_mag_i;
      bm_q   <= b_mag_i;
      aa_q   <= angle_in(a_angle_i);
      ba_q   <= angle_in(b_angle_i);
      xi_q   <= x_in_i;
      yi_q   <= y_in_i;
      prod_q <= PW'(ua) * PW'(uf);
      neg_q  <= a_mag_i[CW-1] ^ factor_i[CW-1];
    end
  end

  // stage 2: scale rounding, operand choice, quadrant fold
  logic [PW:0]          lo2, r, rs, limit;
  logic signed [CW-1:0] scaled, mag_sel;
  logic [31:0]          ang_sel;
  lane_t                lane_a_d, lane_b_d, lane_a_q, lane_b_q;
  side_t                side_d, side_q;

  assign lo2    = {1'b0, prod_q} + (PW + 1)'(1 << (FRAC_BITS - 1));
  assign r      = lo2 >> FRAC_BITS;
  assign limit  = ((PW + 1)'(1) << (CW - 1)) - (PW + 1)'(!neg_q);
  assign rs     = (r > limit) ? limit : r;
  assign scaled = neg_q ? CW'(-rs) : CW'(rs);

  always_comb begin
    mag_sel = am_q;
    ang_sel = aa_q;
    if (func_q == FN_SCALE)     mag_sel = scaled;
    if (func_q == FN_NORMALIZE) mag_sel = CW'(1 << FRAC_BITS);
    if (func_q == FN_ROTATE)    ang_sel = aa_q + ba_q;
  end

  function automatic lane_t fold(input logic signed [CW-1:0] m, input logic [31:0] z);
    lane_t l;
    logic [31:0] zz;
    l.x = IW'(m) <<< GUARD_BITS;
    zz  = z;
    // second and third quadrants: point the other way, turn back by pi
    if (z[31] ^ z[30]) begin
      l.x = -l.x;
      zz  = z - HALF_TURN;
    end
    l.z = ZW'(signed'(zz));
    return l;
  endfunction

  assign lane_a_d    = fold(mag_sel, ang_sel);
  assign lane_b_d    = fold(bm_q, ba_q);
  assign side_d.func = func_q;
  assign side_d.mag  = mag_sel;
  assign side_d.ang  = ang_sel;
  assign side_d.px   = xi_q;
  assign side_d.py   = yi_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_a_q <= lane_a_d;
      lane_b_q <= lane_b_d;
      side_q   <= side_d;
    end
  end

  assign lane_a_o = lane_a_q;
  assign lane_b_o = lane_b_q;
  assign side_o   = side_q;

endmodule

### rtl/pvu_rot.sv
module pvu_rot (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  pvu_pkg::lane_t                         lane_i,
  output logic signed [pvu_pkg::COORD_WIDTH-1:0] x_o,
  output logic signed [pvu_pkg::COORD_WIDTH-1:0] y_o
);
  import pvu_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic signed [IW-1:0] x_q [N];
  logic signed [IW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [IW-1:0] xp, yp;
    logic signed [ZW-1:0] zp, t;
    if (i == 0) begin : g_first
      assign xp = lane_i.x;
      assign yp = '0;
      assign zp = lane_i.z;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end
    assign t = signed'(ZW'(atan_lut(i)));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zp[ZW-1]) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - t;
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + t;
        end
      end
    end
  end

  pvu_gain u_gain_x (
    .clk_i (clk_i),
    .en_i  (en_i),
    .v_i   (x_q[N-1]),
    .y_o   (x_o)
  );

  pvu_gain u_gain_y (
    .clk_i (clk_i),
    .en_i  (en_i),
    .v_i   (y_q[N-1]),
    .y_o   (y_o)
  );

endmodule

### rtl/pvu_vec.sv
module pvu_vec (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] x_i,
  input  logic signed [pvu_pkg::COORD_WIDTH-1:0] y_i,
  output logic signed [pvu_pkg::COORD_WIDTH-1:0] mag_o,
  output logic [31:0]                            ang_o
);
  import pvu_pkg::*;

  localparam int N = CORDIC_STAGES;

  // entry stage: zero test, guard bits, left half-plane fold
  logic signed [IW-1:0] x0_d, y0_d, x0_q, y0_q;
  logic [31:0]          z0_d, z0_q;
  logic                 zero0_q;

  always_comb begin
    x0_d = IW'(x_i) <<< GUARD_BITS;
    y0_d = IW'(y_i) <<< GUARD_BITS;
    z0_d = '0;
    if (x_i[COORD_WIDTH-1]) begin
      x0_d = -x0_d;
      y0_d = -y0_d;
      z0_d = HALF_TURN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= x0_d;
      y0_q    <= y0_d;
      z0_q    <= z0_d;
      zero0_q <= (x_i == '0) && (y_i == '0);
    end
  end

  logic signed [IW-1:0] x_q [N];
  logic signed [IW-1:0] y_q [N];
  logic [31:0]          z_q [N];
  logic                 zero_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [IW-1:0] xp, yp;
    logic [31:0]          zp;
    logic                 zr;
    if (i == 0) begin : g_first
      assign xp = x0_q;
      assign yp = y0_q;
      assign zp = z0_q;
      assign zr = zero0_q;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign zr = zero_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i] <= zr;
        if (!yp[IW-1]) begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + atan_lut(i);
        end else begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - atan_lut(i);
        end
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] mag_g;
  logic [31:0]                   za_q, zb_q;
  logic                          zra_q, zrb_q;

  pvu_gain u_gain (
    .clk_i (clk_i),
    .en_i  (en_i),
    .v_i   (x_q[N-1]),
    .y_o   (mag_g)
  );

  // angle and zero mark held back to meet the gain result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      za_q  <= z_q[N-1];
      zb_q  <= za_q;
      zra_q <= zero_q[N-1];
      zrb_q <= zra_q;
    end
  end

  assign mag_o = zrb_q ? '0 : mag_g;
  assign ang_o = zrb_q ? '0 : zb_q;

endmodule
